### hw/rtl/ecp_pkg.sv
// Shared constants and types for the eviction candidate pool.
package ecp_pkg;

    // Fixed field widths of the result beat.
    localparam int IDLE_W     = 32;
    localparam int OUT_KEY_W  = 32;
    localparam int SLOT_OUT_W = 4;
    localparam int FILL_OUT_W = 5;

    // Item kind codes.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_POP    = 1'b1;

    // Control strobes from the sequencer to the slot store.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_store_ctl;

endpackage

### hw/rtl/ecp_store.sv
// Slot store: one write port and one read port with registered read data.
module ecp_store #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 64
) (
    input  logic                  i_clk,
    input  ecp_pkg::t_store_ctl   i_ctl,
    input  logic [ADDR_W-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0]     i_wr_data,
    input  logic [ADDR_W-1:0]     i_rd_addr,
    output logic [DATA_W-1:0]     o_rd_data
);
    import ecp_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write and read ports; read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/eviction_candidate_pool_unit.sv
// Top level of the eviction candidate pool: sequencer, shared comparator and slot store.
//
//   channel | direction | handshake                   | payload
//   input   | in        | i_in_valid / o_in_ready     | i_kind, i_key_handle, i_idle_time
//   result  | out       | o_out_valid / i_out_ready   | o_inserted ... o_fill_count
//
// An insert compares c slots (none for an empty pool) and moves m entries; each compare
// and each move costs one read and one use of the single store port pair. A dropped sample
// only compares. A pop reads its slot once; an empty pop does not touch the store. Reset
// empties the pool; slot contents are not cleared. A stalled result beat is held in the
// output register while the next item is accepted and worked on; that item waits at its end.
module eviction_candidate_pool_unit #(
    parameter int POOL_SLOTS = 16,
    parameter int KEY_BITS   = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_kind,
    input  logic [KEY_BITS-1:0]               i_key_handle,
    input  logic [ecp_pkg::IDLE_W-1:0]        i_idle_time,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_inserted,
    output logic [ecp_pkg::SLOT_OUT_W-1:0]    o_slot_used,
    output logic                              o_discarded_valid,
    output logic [ecp_pkg::OUT_KEY_W-1:0]     o_discarded_key,
    output logic                              o_popped_valid,
    output logic [ecp_pkg::OUT_KEY_W-1:0]     o_popped_key,
    output logic [ecp_pkg::IDLE_W-1:0]        o_popped_idle,
    output logic [ecp_pkg::FILL_OUT_W-1:0]    o_fill_count
);
    import ecp_pkg::*;

    localparam int IDX_W  = $clog2(POOL_SLOTS);
    localparam int CNT_W  = $clog2(POOL_SLOTS + 1);
    localparam int DATA_W = KEY_BITS + IDLE_W;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(POOL_SLOTS);
    localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_DECIDE,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_WRITE,
        ST_POP_RD,
        ST_FINISH
    } t_state;

    t_state r_state, n_state;

    // Control registers.
    logic [CNT_W-1:0] r_fill, n_fill;
    logic             r_out_valid, n_out_valid;

    // Work registers.
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]    r_dst, n_dst;
    logic [CNT_W-1:0]    r_k, n_k;
    logic [CNT_W-1:0]    r_tgt, n_tgt;
    logic                r_left, n_left;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [IDLE_W-1:0]   r_idle, n_idle;
    logic [KEY_BITS-1:0] r_first_key, n_first_key;
    logic                r_res_ins, n_res_ins;
    logic                r_res_disc, n_res_disc;
    logic                r_res_pop, n_res_pop;

    // Output registers.
    logic                  r_inserted, n_inserted;
    logic [SLOT_OUT_W-1:0] r_slot_used, n_slot_used;
    logic                  r_disc_valid, n_disc_valid;
    logic [OUT_KEY_W-1:0]  r_disc_key, n_disc_key;
    logic                  r_pop_valid, n_pop_valid;
    logic [OUT_KEY_W-1:0]  r_pop_key, n_pop_key;
    logic [IDLE_W-1:0]     r_pop_idle, n_pop_idle;
    logic [FILL_OUT_W-1:0] r_fill_out, n_fill_out;

    // Store interface.
    t_store_ctl        store_ctl;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] rd_data;
    logic [KEY_BITS-1:0] rd_key;
    logic [IDLE_W-1:0]   rd_idle;

    // Width adapters for the fixed result fields.
    logic [KEY_BITS+OUT_KEY_W-1:0] first_key_ext;
    logic [KEY_BITS+OUT_KEY_W-1:0] rd_key_ext;
    logic [CNT_W+SLOT_OUT_W-1:0]   slot_ext;
    logic [CNT_W+FILL_OUT_W-1:0]   fill_ext;

    logic in_fire;
    logic out_free;
    logic idle_less;
    logic pool_full;
    logic [CNT_W-1:0] next_dst;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    assign rd_key  = rd_data[DATA_W-1:IDLE_W];
    assign rd_idle = rd_data[IDLE_W-1:0];

    // Shared comparator: stored idle time against the sample's.
    assign idle_less = (rd_idle < r_idle);
    assign pool_full = (r_fill == FULL);
    assign next_dst  = r_left ? (r_dst + ONE) : (r_dst - ONE);

    assign first_key_ext = {{OUT_KEY_W{1'b0}}, r_first_key};
    assign rd_key_ext    = {{OUT_KEY_W{1'b0}}, rd_key};
    assign slot_ext      = {{SLOT_OUT_W{1'b0}}, r_dst};
    assign fill_ext      = {{FILL_OUT_W{1'b0}}, r_fill};

    // Store port control follows the sequencer state.
    always_comb begin
        store_ctl.rd_en = (r_state == ST_SRCH_RD) || (r_state == ST_MOVE_RD) ||
                          (r_state == ST_POP_RD);
        store_ctl.wr_en = (r_state == ST_MOVE_WR) || (r_state == ST_WRITE);
        wr_addr         = r_dst[IDX_W-1:0];
        wr_data         = (r_state == ST_WRITE) ? {r_key, r_idle} : rd_data;
    end

    ecp_store #(
        .DEPTH  (POOL_SLOTS),
        .ADDR_W (IDX_W),
        .DATA_W (DATA_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (store_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    // Sequencer next state.
    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_out_valid  = r_out_valid;
        n_idx        = r_idx;
        n_dst        = r_dst;
        n_k          = r_k;
        n_tgt        = r_tgt;
        n_left       = r_left;
        n_key        = r_key;
        n_idle       = r_idle;
        n_first_key  = r_first_key;
        n_res_ins    = r_res_ins;
        n_res_disc   = r_res_disc;
        n_res_pop    = r_res_pop;
        n_inserted   = r_inserted;
        n_slot_used  = r_slot_used;
        n_disc_valid = r_disc_valid;
        n_disc_key   = r_disc_key;
        n_pop_valid  = r_pop_valid;
        n_pop_key    = r_pop_key;
        n_pop_idle   = r_pop_idle;
        n_fill_out   = r_fill_out;

        // The result beat leaves when the far side takes it.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_key      = i_key_handle;
                    n_idle     = i_idle_time;
                    n_res_ins  = 1'b0;
                    n_res_disc = 1'b0;
                    n_res_pop  = 1'b0;
                    n_idx      = '0;
                    if (i_kind == KIND_POP) begin
                        if (r_fill == '0) begin
                            n_state = ST_FINISH;
                        end else begin
                            n_idx   = r_fill - ONE;
                            n_state = ST_POP_RD;
                        end
                    end else if (r_fill == '0) begin
                        n_k     = '0;
                        n_state = ST_DECIDE;
                    end else begin
                        n_state = ST_SRCH_RD;
                    end
                end
            end
            ST_SRCH_RD: begin
                n_state = ST_SRCH_CMP;
            end
            ST_SRCH_CMP: begin
                // Slot 0 is the one pushed out when the pool is full.
                if (r_idx == '0) begin
                    n_first_key = rd_key;
                end
                if (!idle_less) begin
                    n_k     = r_idx;
                    n_state = ST_DECIDE;
                end else if (r_idx + ONE == r_fill) begin
                    n_k     = r_fill;
                    n_state = ST_DECIDE;
                end else begin
                    n_idx   = r_idx + ONE;
                    n_state = ST_SRCH_RD;
                end
            end
            ST_DECIDE: begin
                if (pool_full && r_k == '0) begin
                    // Sample not above the smallest entry of a full pool.
                    n_state = ST_FINISH;
                end else if (!pool_full && r_k == r_fill) begin
                    n_dst   = r_k;
                    n_fill  = r_fill + ONE;
                    n_state = ST_WRITE;
                end else if (!pool_full) begin
                    // Open a hole at the found slot by moving the tail right.
                    n_left  = 1'b0;
                    n_dst   = r_fill;
                    n_idx   = r_fill - ONE;
                    n_tgt   = r_k;
                    n_fill  = r_fill + ONE;
                    n_state = ST_MOVE_RD;
                end else begin
                    // Push out slot 0 and move the lower entries left.
                    n_res_disc = 1'b1;
                    n_left     = 1'b1;
                    n_dst      = '0;
                    n_idx      = ONE;
                    n_tgt      = r_k - ONE;
                    n_state    = (r_k == ONE) ? ST_WRITE : ST_MOVE_RD;
                end
            end
            ST_MOVE_RD: begin
                n_state = ST_MOVE_WR;
            end
            ST_MOVE_WR: begin
                n_dst   = next_dst;
                n_idx   = r_left ? (r_idx + ONE) : (r_idx - ONE);
                n_state = (next_dst == r_tgt) ? ST_WRITE : ST_MOVE_RD;
            end
            ST_WRITE: begin
                n_res_ins = 1'b1;
                n_state   = ST_FINISH;
            end
            ST_POP_RD: begin
                n_res_pop = 1'b1;
                n_fill    = r_fill - ONE;
                n_state   = ST_FINISH;
            end
            ST_FINISH: begin
                // Load the result beat once the output register is free.
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_inserted   = r_res_ins;
                    n_slot_used  = r_res_ins ? slot_ext[SLOT_OUT_W-1:0] : '0;
                    n_disc_valid = r_res_disc;
                    n_disc_key   = r_res_disc ? first_key_ext[OUT_KEY_W-1:0] : '0;
                    n_pop_valid  = r_res_pop;
                    n_pop_key    = r_res_pop ? rd_key_ext[OUT_KEY_W-1:0] : '0;
                    n_pop_idle   = r_res_pop ? rd_idle : '0;
                    n_fill_out   = fill_ext[FILL_OUT_W-1:0];
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State, work and output registers; reset clears control only.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
        r_idx        <= n_idx;
        r_dst        <= n_dst;
        r_k          <= n_k;
        r_tgt        <= n_tgt;
        r_left       <= n_left;
        r_key        <= n_key;
        r_idle       <= n_idle;
        r_first_key  <= n_first_key;
        r_res_ins    <= n_res_ins;
        r_res_disc   <= n_res_disc;
        r_res_pop    <= n_res_pop;
        r_inserted   <= n_inserted;
        r_slot_used  <= n_slot_used;
        r_disc_valid <= n_disc_valid;
        r_disc_key   <= n_disc_key;
        r_pop_valid  <= n_pop_valid;
        r_pop_key    <= n_pop_key;
        r_pop_idle   <= n_pop_idle;
        r_fill_out   <= n_fill_out;
    end

    assign o_out_valid       = r_out_valid;
    assign o_inserted        = r_inserted;
    assign o_slot_used       = r_slot_used;
    assign o_discarded_valid = r_disc_valid;
    assign o_discarded_key   = r_disc_key;
    assign o_popped_valid    = r_pop_valid;
    assign o_popped_key      = r_pop_key;
    assign o_popped_idle     = r_pop_idle;
    assign o_fill_count      = r_fill_out;

    // The fill count never exceeds the pool size.
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL)
        else $error("fill count above pool size");

    // A result beat never both inserts and pops.
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_inserted && o_popped_valid))
        else $error("result beat reports insert and pop together");

    // An entry is pushed out only by a sample that takes its place in a full pool.
    a_disc_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_discarded_valid) |->
            (o_inserted && o_fill_count == FILL_OUT_W'(POOL_SLOTS)))
        else $error("push-out without insert into full pool");

    // Store writes stay inside the pool.
    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        store_ctl.wr_en |-> (r_dst < FULL))
        else $error("store write beyond last slot");

    // A moved entry lands next to its source slot.
    a_move_adjacent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MOVE_WR) |-> ((r_idx + ONE == r_dst) || (r_dst + ONE == r_idx)))
        else $error("move between slots that are not neighbors");

endmodule

### tb/eviction_candidate_pool_unit_tb.sv
// Self-checking testbench for the eviction candidate pool unit.
module eviction_candidate_pool_unit_tb;
    import ecp_pkg::*;

    localparam int SLOTS           = 16;
    localparam int KEY_W           = 32;
    localparam int LIMIT_CYCLES    = 600000;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 80;
    localparam int ITEMS_PER_PHASE = 350;

    // One result beat as the block presents it.
    typedef struct {
        logic                  inserted;
        logic [SLOT_OUT_W-1:0] slot_used;
        logic                  discarded_valid;
        logic [OUT_KEY_W-1:0]  discarded_key;
        logic                  popped_valid;
        logic [OUT_KEY_W-1:0]  popped_key;
        logic [IDLE_W-1:0]     popped_idle;
        logic [FILL_OUT_W-1:0] fill_count;
    } t_outcome;

    // One row of the directed stimulus; typed rows carry their own outcome.
    typedef struct {
        logic              kind;
        logic [KEY_W-1:0]  key;
        logic [IDLE_W-1:0] idle;
        bit                typed;
        t_outcome          want;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_kind = KIND_INSERT;
    logic [KEY_W-1:0]      i_key_handle = '0;
    logic [IDLE_W-1:0]     i_idle_time = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_inserted;
    logic [SLOT_OUT_W-1:0] o_slot_used;
    logic                  o_discarded_valid;
    logic [OUT_KEY_W-1:0]  o_discarded_key;
    logic                  o_popped_valid;
    logic [OUT_KEY_W-1:0]  o_popped_key;
    logic [IDLE_W-1:0]     o_popped_idle;
    logic [FILL_OUT_W-1:0] o_fill_count;

    // Shadow copy of the pool, kept packed left and sorted by idle time.
    logic              pool_busy [SLOTS];
    logic [KEY_W-1:0]  pool_key  [SLOTS];
    logic [IDLE_W-1:0] pool_idle [SLOTS];

    t_outcome  pending_outcomes[$];
    t_stim_row directed_rows[$];
    t_outcome  seen_want;
    t_outcome  seen_got;

    int mismatch_count = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    eviction_candidate_pool_unit #(
        .POOL_SLOTS(SLOTS),
        .KEY_BITS  (KEY_W)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_key_handle     (i_key_handle),
        .i_idle_time      (i_idle_time),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_inserted       (o_inserted),
        .o_slot_used      (o_slot_used),
        .o_discarded_valid(o_discarded_valid),
        .o_discarded_key  (o_discarded_key),
        .o_popped_valid   (o_popped_valid),
        .o_popped_key     (o_popped_key),
        .o_popped_idle    (o_popped_idle),
        .o_fill_count     (o_fill_count)
    );

    // Free-running clock with a period of 10.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Copy one shadow slot onto another.
    function automatic void move_entry(input int dst, input int src);
        pool_busy[dst] = pool_busy[src];
        pool_key[dst]  = pool_key[src];
        pool_idle[dst] = pool_idle[src];
    endfunction

    function automatic int pool_fill();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++) begin
            if (pool_busy[i]) n++;
        end
        return n;
    endfunction

    // Apply one item to the shadow pool and return the beat it should produce.
    function automatic t_outcome apply_pool_item(input logic kind, input logic [KEY_W-1:0] key,
                                                 input logic [IDLE_W-1:0] idle);
        t_outcome res;
        int       k;
        logic     last_full;
        res = '{default: '0};
        if (kind == KIND_INSERT) begin
            last_full = pool_busy[SLOTS-1];
            k = 0;
            while (k < SLOTS && pool_busy[k] && pool_idle[k] < idle) k++;
            // A full pool drops a sample that is not above its smallest entry.
            if (!(k == 0 && last_full)) begin
                if (k < SLOTS && !pool_busy[k]) begin
                    // The sample lands in the first free slot.
                end else if (!last_full) begin
                    for (int i = SLOTS - 1; i > k; i--) move_entry(i, i - 1);
                end else begin
                    k--;
                    res.discarded_valid = 1'b1;
                    res.discarded_key   = pool_key[0];
                    for (int i = 0; i < k; i++) move_entry(i, i + 1);
                end
                pool_busy[k]  = 1'b1;
                pool_key[k]   = key;
                pool_idle[k]  = idle;
                res.inserted  = 1'b1;
                res.slot_used = k[SLOT_OUT_W-1:0];
            end
        end else begin
            // Take out the highest occupied slot and close the gap.
            for (k = SLOTS - 1; k >= 0; k--) begin
                if (pool_busy[k]) begin
                    res.popped_valid = 1'b1;
                    res.popped_key   = pool_key[k];
                    res.popped_idle  = pool_idle[k];
                    for (int i = k; i < SLOTS - 1; i++) move_entry(i, i + 1);
                    pool_busy[SLOTS-1] = 1'b0;
                    break;
                end
            end
        end
        res.fill_count = FILL_OUT_W'(pool_fill());
        return res;
    endfunction

    task automatic report_mismatch(input string field_name, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s at cycle %0d: got %h, expected %h",
                 field_name, cycle_count, got, want);
        mismatch_count++;
    endtask

    task automatic compare_outcome(input t_outcome want, input t_outcome got);
        if (got.inserted !== want.inserted)
            report_mismatch("inserted", got.inserted, want.inserted);
        if (got.slot_used !== want.slot_used)
            report_mismatch("slot_used", got.slot_used, want.slot_used);
        if (got.discarded_valid !== want.discarded_valid)
            report_mismatch("discarded_valid", got.discarded_valid, want.discarded_valid);
        if (got.discarded_key !== want.discarded_key)
            report_mismatch("discarded_key", got.discarded_key, want.discarded_key);
        if (got.popped_valid !== want.popped_valid)
            report_mismatch("popped_valid", got.popped_valid, want.popped_valid);
        if (got.popped_key !== want.popped_key)
            report_mismatch("popped_key", got.popped_key, want.popped_key);
        if (got.popped_idle !== want.popped_idle)
            report_mismatch("popped_idle", got.popped_idle, want.popped_idle);
        if (got.fill_count !== want.fill_count)
            report_mismatch("fill_count", got.fill_count, want.fill_count);
    endtask

    // Offer one beat, possibly after an idle gap, and record its outcome once taken.
    task automatic offer_item(input logic kind, input logic [KEY_W-1:0] key,
                              input logic [IDLE_W-1:0] idle, input bit typed,
                              input t_outcome want);
        t_outcome pred;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid   <= 1'b0;
            i_kind       <= 1'($urandom_range(1));
            i_key_handle <= $urandom;
            i_idle_time  <= $urandom;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_key_handle <= key;
        i_idle_time  <= idle;
        do @(posedge i_clk); while (!o_in_ready);
        pred = apply_pool_item(kind, key, idle);
        pending_outcomes.push_back(typed ? want : pred);
    endtask

    // Drop valid and wait until every outstanding beat has come back.
    task automatic drain_outcomes();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_outcomes.size() != 0);
    endtask

    function automatic void add_row(input logic kind, input logic [KEY_W-1:0] key,
                                    input logic [IDLE_W-1:0] idle, input bit typed,
                                    input t_outcome want);
        t_stim_row row;
        row.kind  = kind;
        row.key   = key;
        row.idle  = idle;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check each result beat against the oldest outstanding outcome.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen_got = '{o_inserted, o_slot_used, o_discarded_valid, o_discarded_key,
                         o_popped_valid, o_popped_key, o_popped_idle, o_fill_count};
            if (pending_outcomes.size() == 0) begin
                report_mismatch("beat with no outcome pending", 1, 0);
            end else begin
                seen_want = pending_outcomes.pop_front();
                compare_outcome(seen_want, seen_got);
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        t_outcome          none;
        t_outcome          want;
        logic              r_kind;
        logic [IDLE_W-1:0] r_idle;
        int                pop_pct;
        int                fill;

        none = '{default: '0};
        for (int i = 0; i < SLOTS; i++) begin
            pool_busy[i] = 1'b0;
            pool_key[i]  = '0;
            pool_idle[i] = '0;
        end

        // Directed rows: empty pop, extremes, equal idles, full pool cases.
        add_row(KIND_POP, '0, '0, 1'b1, none);
        want = none;
        want.inserted   = 1'b1;
        want.fill_count = FILL_OUT_W'(1);
        add_row(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, want);
        add_row(KIND_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b0, none);
        add_row(KIND_INSERT, 32'h0000_0001, 32'h0000_0000, 1'b0, none);
        add_row(KIND_POP, '0, '0, 1'b0, none);
        for (int i = 1; i <= 14; i++)
            add_row(KIND_INSERT, 32'hA5A5_0000 + i, i * 1000, 1'b0, none);
        // The pool is now full with a smallest idle of zero, so this sample is dropped.
        want = none;
        want.fill_count = FILL_OUT_W'(SLOTS);
        add_row(KIND_INSERT, 32'h5A5A_5A5A, 32'h0000_0000, 1'b1, want);
        add_row(KIND_INSERT, 32'h1234_5678, 32'h0000_0005, 1'b0, none);
        add_row(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, none);
        add_row(KIND_POP, '0, '0, 1'b0, none);
        add_row(KIND_INSERT, 32'h8000_0001, 32'h0000_0007, 1'b0, none);
        add_row(KIND_POP, '0, '0, 1'b0, none);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            offer_item(directed_rows[r].kind, directed_rows[r].key, directed_rows[r].idle,
                       directed_rows[r].typed, directed_rows[r].want);
        drain_outcomes();

        // Random items over four idling phases.
        pop_pct = 30;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Swing between filling and draining the pool.
                if (n % 50 == 0) begin
                    case ($urandom_range(2))
                        0: pop_pct = 10;
                        1: pop_pct = 35;
                        default: pop_pct = 60;
                    endcase
                end
                if (phase == 0 && n == 120) hold_req++;
                if (phase == 2 && n == 175) drain_outcomes();

                r_kind = ($urandom_range(99) < pop_pct) ? KIND_POP : KIND_INSERT;
                fill = pool_fill();
                case ($urandom_range(9))
                    0: r_idle = '0;
                    1: r_idle = 32'hFFFF_FFFF;
                    2, 3: r_idle = $urandom_range(15);
                    4, 5: r_idle = (fill > 0) ? pool_idle[$urandom_range(fill - 1)] : $urandom;
                    6: r_idle = (fill > 0) ? pool_idle[$urandom_range(fill - 1)] + 1 : $urandom;
                    7: r_idle = (fill > 0) ? pool_idle[$urandom_range(fill - 1)] - 1 : $urandom;
                    default: r_idle = $urandom;
                endcase
                offer_item(r_kind, $urandom, r_idle, 1'b0, none);
            end
            drain_outcomes();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
